### hdl/mfrp_pkg.sv
`timescale 1ns / 1ps

package mfrp_pkg;

	typedef enum logic [3:0] {
		PH_LEN   = 4'd0,
		PH_FCF   = 4'd1,
		PH_SEQ   = 4'd2,
		PH_DPAN  = 4'd3,
		PH_DADDR = 4'd4,
		PH_SPAN  = 4'd5,
		PH_SADDR = 4'd6,
		PH_PAY   = 4'd7,
		PH_TRAIL = 4'd8
	} phase_t;

	localparam logic ACT_BYTE  = 1'b0;
	localparam logic ACT_FLUSH = 1'b1;

	localparam logic [1:0] ADDR_MODE_SHORT = 2'd2;
	localparam logic [1:0] ADDR_MODE_EXT   = 2'd3;

	localparam logic [1:0] CLS_BEACON  = 2'd0;
	localparam logic [1:0] CLS_DATA    = 2'd1;
	localparam logic [1:0] CLS_ACK     = 2'd2;
	localparam logic [1:0] CLS_COMMAND = 2'd3;

	localparam logic [2:0] FT_BEACON = 3'd0;
	localparam logic [2:0] FT_DATA   = 3'd1;
	localparam logic [2:0] FT_ACK    = 3'd2;

	// Five fixed header bytes plus the two trailer bytes.
	localparam int unsigned MIN_FRAME_BYTES = 7;
	localparam logic [4:0]  FIXED_NEED      = 5'd5;

	typedef struct packed {
		logic       action;
		logic [7:0] rx_byte;
	} rx_item_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic [3:0] field_code;
		logic [6:0] field_index;
		logic       frame_done;
		logic [1:0] frame_class;
		logic [6:0] payload_bytes;
		logic       length_error;
	} rx_result_t;

	// What the front hands to the back through the queue.
	typedef struct packed {
		logic [7:0] byte_value;
		logic [3:0] field_code;
		logic [6:0] field_index;
		logic       frame_done;
		logic [2:0] frame_type;
		logic [6:0] payload_count;
		logic       length_error;
	} front_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	function automatic logic [3:0] addr_bytes(input logic [1:0] mode);
		logic [3:0] n;
		case (mode)
			ADDR_MODE_SHORT: n = 4'd2;
			ADDR_MODE_EXT:   n = 4'd8;
			default:         n = 4'd0;
		endcase
		return n;
	endfunction

endpackage

### hdl/mfrp_front.sv
`timescale 1ns / 1ps

module mfrp_front import mfrp_pkg::*; #(
	parameter int unsigned MAX_FRAME_BYTES = 127
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_wdata,
	input  logic          in_valid,
	output logic          in_stall,
	input  rx_item_t      in_data,
	input  queue_status_t q_status,
	output logic          push,
	output front_item_t   push_item
);

	localparam int unsigned LEFT_W = $clog2(MAX_FRAME_BYTES + 1);

	phase_t              phase_q, phase_d;
	logic [LEFT_W-1:0]   field_count_q, field_count_d;
	logic [LEFT_W-1:0]   bytes_left_q, bytes_left_d;
	logic [15:0]         fcf_q, fcf_d;
	logic                pan_comp_q;

	logic                take, is_byte, flush;
	logic [7:0]          b;
	logic [15:0]         fcf_new;
	logic [3:0]          size_cur;
	logic [LEFT_W-1:0]   bl_dec, bl_sat, fc_inc;
	logic                bl_low, hdr_ph, hdr_done, need_fail, len_bad;
	logic [4:0]          need;
	phase_t              after_hdr, after_hdr_adj;
	logic                hdr_err, len_err, trail_end;

	function automatic logic [3:0] size_of(input phase_t ph, input logic [15:0] fcf,
			input logic pc);
		logic [3:0] n;
		case (ph)
			PH_FCF:   n = 4'd2;
			PH_SEQ:   n = 4'd1;
			PH_DPAN:  n = 4'd2;
			PH_DADDR: n = addr_bytes(fcf[11:10]);
			PH_SPAN:  n = pc ? 4'd0 : 4'd2;
			PH_SADDR: n = addr_bytes(fcf[15:14]);
			default:  n = 4'd0;
		endcase
		return n;
	endfunction

	// First header field after ph that has any bytes, else the payload.
	function automatic phase_t next_hdr(input phase_t ph, input logic [15:0] fcf,
			input logic pc);
		phase_t nx;
		nx = PH_PAY;
		for (int k = int'(PH_SADDR); k >= int'(PH_SEQ); k--) begin
			if (k > int'(ph) && size_of(phase_t'(4'(k)), fcf, pc) != 4'd0) begin
				nx = phase_t'(4'(k));
			end
		end
		return nx;
	endfunction

	assign in_stall = q_status.full;
	assign take     = in_valid && !q_status.full;
	assign is_byte  = take && (in_data.action == ACT_BYTE);
	assign flush    = take && (in_data.action == ACT_FLUSH);
	assign b        = in_data.rx_byte;

	assign fcf_new   = (phase_q == PH_FCF)
		? (fcf_q | ({8'h00, b} << {field_count_q[0], 3'b000})) : fcf_q;
	assign size_cur  = size_of(phase_q, fcf_q, pan_comp_q);
	assign bl_dec    = bytes_left_q - LEFT_W'(1);
	assign bl_sat    = (bytes_left_q == '0) ? '0 : bl_dec;
	assign bl_low    = bytes_left_q <= LEFT_W'(2);
	assign fc_inc    = field_count_q + LEFT_W'(1);
	assign hdr_ph    = (phase_q >= PH_FCF) && (phase_q <= PH_SADDR);
	assign hdr_done  = fc_inc >= LEFT_W'(size_cur);
	assign need      = FIXED_NEED + 5'(addr_bytes(fcf_new[11:10]))
		+ (pan_comp_q ? 5'd0 : 5'd2) + 5'(addr_bytes(fcf_new[15:14]));
	assign need_fail = bl_dec < LEFT_W'(need);
	assign len_bad   = (9'(b) < 9'(MIN_FRAME_BYTES)) || (9'(b) > 9'(MAX_FRAME_BYTES));
	assign after_hdr = next_hdr(phase_q, fcf_new, pan_comp_q);
	assign after_hdr_adj = (after_hdr == PH_PAY && bl_dec <= LEFT_W'(2)) ? PH_TRAIL
		: after_hdr;

	assign hdr_err   = hdr_ph && (bl_low || (hdr_done && phase_q == PH_FCF && need_fail));
	assign len_err   = !hdr_ph && phase_q != PH_PAY && phase_q != PH_TRAIL && len_bad;
	assign trail_end = (phase_q == PH_TRAIL) && (bl_sat == '0);

	// Next state of the parser for a consumed byte.
	always_comb begin
		phase_d       = phase_q;
		field_count_d = field_count_q;
		bytes_left_d  = bytes_left_q;
		fcf_d         = fcf_q;
		case (phase_q) inside
			[PH_FCF:PH_SADDR]: begin
				if (bl_low) begin
					phase_d       = PH_LEN;
					field_count_d = '0;
					bytes_left_d  = '0;
				end else begin
					bytes_left_d  = bl_dec;
					fcf_d         = fcf_new;
					field_count_d = fc_inc;
					if (hdr_done) begin
						field_count_d = '0;
						if (phase_q == PH_FCF && need_fail) begin
							phase_d      = PH_LEN;
							bytes_left_d = '0;
						end else begin
							phase_d = after_hdr_adj;
						end
					end
				end
			end
			PH_PAY: begin
				bytes_left_d  = bl_sat;
				field_count_d = fc_inc;
				if (bl_sat <= LEFT_W'(2)) begin
					phase_d = PH_TRAIL;
				end
			end
			PH_TRAIL: begin
				bytes_left_d = bl_sat;
				if (bl_sat == '0) begin
					phase_d       = PH_LEN;
					field_count_d = '0;
				end
			end
			default: begin
				field_count_d = '0;
				if (len_bad) begin
					phase_d      = PH_LEN;
					bytes_left_d = '0;
				end else begin
					phase_d      = PH_FCF;
					bytes_left_d = LEFT_W'(b);
					fcf_d        = '0;
				end
			end
		endcase
	end

	// Tagging of the consumed byte.
	always_comb begin
		push                    = is_byte;
		push_item.byte_value    = b;
		push_item.field_code    = phase_q;
		push_item.field_index   = 7'(field_count_q);
		push_item.frame_done    = trail_end;
		push_item.frame_type    = fcf_q[2:0];
		push_item.payload_count = 7'(field_count_q);
		push_item.length_error  = hdr_err || len_err;
		case (phase_q) inside
			[PH_FCF:PH_PAY]: begin
			end
			PH_TRAIL: begin
				push_item.field_index = (bytes_left_q >= LEFT_W'(2)) ? 7'd0 : 7'd1;
			end
			default: begin
				push_item.field_code  = PH_LEN;
				push_item.field_index = 7'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_LEN;
			field_count_q <= '0;
			bytes_left_q  <= '0;
			fcf_q         <= '0;
			pan_comp_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				pan_comp_q <= cfg_wdata;
			end
			if (flush) begin
				phase_q       <= PH_LEN;
				field_count_q <= '0;
				bytes_left_q  <= '0;
			end else if (is_byte) begin
				phase_q       <= phase_d;
				field_count_q <= field_count_d;
				bytes_left_q  <= bytes_left_d;
				fcf_q         <= fcf_d;
			end
		end
	end

	a_err_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		push && push_item.length_error |-> !push_item.frame_done)
		else $error("front: error result also marked as frame end");

	a_flush_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		flush |=> phase_q == PH_LEN && bytes_left_q == '0)
		else $error("front: flush did not resync the parser");

endmodule

### hdl/mfrp_queue.sv
`timescale 1ns / 1ps

module mfrp_queue import mfrp_pkg::*; #(
	parameter int unsigned DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  front_item_t   push_item,
	input  logic          pop,
	output front_item_t   pop_item,
	output queue_status_t status
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	front_item_t   entries_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign status.full  = count_q == CW'(DEPTH);
	assign status.empty = count_q == '0;
	assign pop_item     = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		status.full |-> !push)
		else $error("queue: write while full");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue: fill count beyond depth");

endmodule

### hdl/mfrp_back.sv
`timescale 1ns / 1ps

module mfrp_back import mfrp_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  queue_status_t q_status,
	output logic          pop,
	input  front_item_t   pop_item,
	output logic          out_valid,
	input  logic          out_stall,
	output rx_result_t    out_data
);

	logic       out_valid_q;
	rx_result_t out_data_q;
	rx_result_t res;

	assign pop       = !q_status.empty && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Class and payload length only mean something on the last byte of a frame.
	always_comb begin
		res.byte_value    = pop_item.byte_value;
		res.field_code    = pop_item.field_code;
		res.field_index   = pop_item.field_index;
		res.frame_done    = pop_item.frame_done;
		res.length_error  = pop_item.length_error;
		res.frame_class   = CLS_BEACON;
		res.payload_bytes = 7'd0;
		if (pop_item.frame_done) begin
			res.payload_bytes = pop_item.payload_count;
			case (pop_item.frame_type)
				FT_BEACON: res.frame_class = CLS_BEACON;
				FT_DATA:   res.frame_class = CLS_DATA;
				FT_ACK:    res.frame_class = CLS_ACK;
				default:   res.frame_class = CLS_COMMAND;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_data_q <= res;
		end
	end

	a_idle_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_data_q.frame_done
			|-> out_data_q.frame_class == CLS_BEACON && out_data_q.payload_bytes == 7'd0)
		else $error("back: class or length set outside a frame end");

endmodule

### hdl/mac_frame_rx_parser_unit.sv
`timescale 1ns / 1ps

// Receive-side IEEE 802.15.4 MAC header parser. Each input transaction carries one frame
// byte (or a flush, which resyncs the parser to the length byte and yields no result);
// every byte comes back tagged with its field and its position in that field, and the
// last byte of a frame also carries the frame class and the payload length. The block
// takes one byte every clock cycle unless in_stall is high: the parse state in the front is
// updated once per byte, and each result goes through the queue and then the output register.
// A queue of QUEUE_DEPTH entries between the parser and the output register absorbs
// output stalls; in_stall rises only when that queue is full.

module mac_frame_rx_parser_unit import mfrp_pkg::*; #(
	parameter int unsigned MAX_FRAME_BYTES = 127,
	parameter int unsigned QUEUE_DEPTH     = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic       in_valid,
	output logic       in_stall,
	input  rx_item_t   in_data,
	output logic       out_valid,
	input  logic       out_stall,
	output rx_result_t out_data
);

	queue_status_t q_status;
	logic          push, pop;
	front_item_t   push_item, pop_item;

	mfrp_front #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.q_status  (q_status),
		.push      (push),
		.push_item (push_item)
	);

	mfrp_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.status    (q_status)
	);

	mfrp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_status  (q_status),
		.pop       (pop),
		.pop_item  (pop_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

### tb/sv/rx_parse_checker.sv
`timescale 1ns / 1ps

module rx_parse_checker import mfrp_pkg::*; #(
	parameter int unsigned MAX_FRAME_BYTES = 127
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic       in_valid,
	input  logic       in_stall,
	input  rx_item_t   in_data,
	input  logic       out_valid,
	input  logic       out_stall,
	input  rx_result_t out_data,
	output int         n_fail,
	output int         n_pending,
	output int         n_results,
	output int         n_frames,
	output int         n_len_errors
);

	phase_t      cur_field;
	logic [6:0]  field_pos;
	logic [6:0]  frame_left;
	logic [15:0] fcf_seen;
	logic        span_absent;
	rx_result_t  pending_tags[$];
	int          fails = 0;
	int          results = 0;
	int          frames = 0;
	int          len_errors = 0;

	function automatic int unsigned addr_len(input logic [1:0] mode);
		int unsigned n;
		n = 0;
		if (mode == ADDR_MODE_SHORT)
			n = 2;
		else if (mode == ADDR_MODE_EXT)
			n = 8;
		return n;
	endfunction

	function automatic int unsigned field_len(input phase_t f);
		int unsigned n;
		case (f)
			PH_FCF, PH_DPAN: n = 2;
			PH_SEQ:          n = 1;
			PH_DADDR:        n = addr_len(fcf_seen[11:10]);
			PH_SPAN:         n = span_absent ? 0 : 2;
			PH_SADDR:        n = addr_len(fcf_seen[15:14]);
			default:         n = 0;
		endcase
		return n;
	endfunction

	task automatic abandon_frame();
		cur_field = PH_LEN;
		field_pos = '0;
		frame_left = '0;
	endtask

	task automatic next_field();
		int unsigned nx;
		nx = int'(cur_field) + 1;
		while (nx <= PH_SADDR && field_len(phase_t'(nx)) == 0)
			nx++;
		// With two bytes or fewer to go there is no payload, only the trailer.
		if (nx == PH_PAY && frame_left <= 2)
			nx = PH_TRAIL;
		cur_field = phase_t'(nx);
		field_pos = '0;
	endtask

	task automatic tag_byte(input rx_item_t it);
		rx_result_t  tag;
		int unsigned need;
		tag = '0;
		if (it.action == ACT_FLUSH) begin
			abandon_frame();
			return;
		end
		tag.byte_value = it.rx_byte;
		tag.field_code = cur_field;
		if (cur_field >= PH_FCF && cur_field <= PH_SADDR) begin
			tag.field_index = field_pos;
			if (frame_left <= 2) begin
				// Only the trailer may still come, so a header byte here means the
				// header grew after the length was checked.
				tag.length_error = 1'b1;
				abandon_frame();
			end else begin
				frame_left--;
				if (cur_field == PH_FCF) begin
					if (field_pos == 0)
						fcf_seen[7:0] = it.rx_byte;
					else
						fcf_seen[15:8] = it.rx_byte;
				end
				field_pos++;
				if (field_pos >= field_len(cur_field)) begin
					need = 5 + addr_len(fcf_seen[11:10]) + (span_absent ? 0 : 2)
						+ addr_len(fcf_seen[15:14]);
					if (cur_field == PH_FCF && frame_left < need) begin
						tag.length_error = 1'b1;
						abandon_frame();
					end else begin
						next_field();
					end
				end
			end
		end else if (cur_field == PH_PAY) begin
			tag.field_index = field_pos;
			if (frame_left > 0)
				frame_left--;
			field_pos++;
			if (frame_left <= 2)
				cur_field = PH_TRAIL;
		end else if (cur_field == PH_TRAIL) begin
			tag.field_index = (frame_left >= 2) ? 7'd0 : 7'd1;
			if (frame_left > 0)
				frame_left--;
			if (frame_left == 0) begin
				tag.frame_done = 1'b1;
				case (fcf_seen[2:0])
					FT_BEACON: tag.frame_class = CLS_BEACON;
					FT_DATA:   tag.frame_class = CLS_DATA;
					FT_ACK:    tag.frame_class = CLS_ACK;
					default:   tag.frame_class = CLS_COMMAND;
				endcase
				// In the trailer the field counter still holds the payload count.
				tag.payload_bytes = field_pos;
				cur_field = PH_LEN;
				field_pos = '0;
			end
		end else begin
			tag.field_code = PH_LEN;
			if (it.rx_byte < MIN_FRAME_BYTES || it.rx_byte > MAX_FRAME_BYTES) begin
				tag.length_error = 1'b1;
				abandon_frame();
			end else begin
				frame_left = it.rx_byte[6:0];
				fcf_seen = '0;
				cur_field = PH_FCF;
				field_pos = '0;
			end
		end
		pending_tags.push_back(tag);
	endtask

	task automatic check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endtask

	task automatic check_result(input rx_result_t got);
		rx_result_t want;
		results++;
		if (pending_tags.size() == 0) begin
			$error("unexpected result transaction: byte_value %0d field_code %0d",
				got.byte_value, got.field_code);
			fails++;
			return;
		end
		want = pending_tags.pop_front();
		if (want.frame_done)
			frames++;
		if (want.length_error)
			len_errors++;
		check_field("byte_value", want.byte_value, got.byte_value);
		check_field("field_code", 8'(want.field_code), 8'(got.field_code));
		check_field("field_index", 8'(want.field_index), 8'(got.field_index));
		check_field("frame_done", 8'(want.frame_done), 8'(got.frame_done));
		check_field("frame_class", 8'(want.frame_class), 8'(got.frame_class));
		check_field("payload_bytes", 8'(want.payload_bytes), 8'(got.payload_bytes));
		check_field("length_error", 8'(want.length_error), 8'(got.length_error));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_absent = 1'b0;
			fcf_seen = '0;
			abandon_frame();
			pending_tags.delete();
		end else begin
			// A result leaves only after its byte has been taken, so the compare goes first.
			if (out_valid && !out_stall)
				check_result(out_data);
			if (in_valid && !in_stall)
				tag_byte(in_data);
			if (cfg_we)
				span_absent = cfg_wdata;
		end
		n_fail <= fails;
		n_pending <= pending_tags.size();
		n_results <= results;
		n_frames <= frames;
		n_len_errors <= len_errors;
	end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import mfrp_pkg::*;

	localparam int unsigned MAX_FRAME    = 127;
	localparam int          SETTLE       = 8;
	localparam int          STALL_LIMIT  = 4000;
	localparam int          RANDOM_ITEMS = 650;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic       cfg_wdata = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	rx_item_t   in_data = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	rx_result_t out_data;

	int   n_fail, n_pending, n_results, n_frames, n_len_errors;
	int   src_idle_pct = 35;
	int   dst_idle_pct = 64;
	int   bytes_sent = 0;
	int   pan_writes = 0;
	int   quiet_cycles = 0;
	logic pan_setting = 1'b0;

	mac_frame_rx_parser_unit #(
		.MAX_FRAME_BYTES(MAX_FRAME)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	rx_parse_checker #(
		.MAX_FRAME_BYTES(MAX_FRAME)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data),
		.n_fail      (n_fail),
		.n_pending   (n_pending),
		.n_results   (n_results),
		.n_frames    (n_frames),
		.n_len_errors(n_len_errors)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < dst_idle_pct);
	end

	// Counts cycles in which neither channel completes a transaction.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL mac_frame_rx_parser_unit");
			$finish;
		end
	end

	task automatic send(input logic act, input logic [7:0] b);
		rx_item_t it;
		it.action = act;
		it.rx_byte = b;
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (n_pending != 0)
			@(posedge clk);
		// A flush leaves nothing to wait for, so let the block settle before going on.
		repeat (SETTLE)
			@(posedge clk);
	endtask

	task automatic write_pan_setting(input logic v);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		pan_setting = v;
		pan_writes++;
	endtask

	task automatic send_frame();
		logic [15:0] fcf;
		int unsigned body, pay, flen, cut, pick;
		fcf = 16'($urandom);
		body = 5 + (pan_setting ? 0 : 2);
		body += (fcf[11:10] == ADDR_MODE_SHORT) ? 2 : (fcf[11:10] == ADDR_MODE_EXT) ? 8 : 0;
		body += (fcf[15:14] == ADDR_MODE_SHORT) ? 2 : (fcf[15:14] == ADDR_MODE_EXT) ? 8 : 0;
		pick = $urandom_range(19);
		if (pick == 0)
			pay = MAX_FRAME - body - 2;
		else if (pick < 3)
			pay = $urandom_range(MAX_FRAME - body - 2);
		else
			pay = $urandom_range(8);
		flen = body + pay + 2;
		// Now and then the length is too short for the header, or the frame is cut by a flush.
		pick = $urandom_range(19);
		if (pick == 0) begin
			if (body + 1 >= MIN_FRAME_BYTES)
				flen = $urandom_range(MIN_FRAME_BYTES, body + 1);
			else
				flen = $urandom_range(MIN_FRAME_BYTES - 1);
		end
		cut = (pick == 1) ? $urandom_range(1, flen) : flen + 1;
		send(ACT_BYTE, 8'(flen));
		for (int i = 1; i <= flen; i++) begin
			if (i == cut) begin
				send(ACT_FLUSH, 8'($urandom));
				return;
			end
			if (i == 1)
				send(ACT_BYTE, fcf[7:0]);
			else if (i == 2)
				send(ACT_BYTE, fcf[15:8]);
			else
				send(ACT_BYTE, 8'($urandom));
		end
	endtask

	initial begin
		int phase_end;
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Length bytes out of range at both ends.
		send(ACT_BYTE, 8'd0);
		send(ACT_BYTE, 8'd6);
		send(ACT_BYTE, 8'd128);
		send(ACT_BYTE, 8'd255);
		// With the source PAN present a seven-byte frame cannot hold its header; both
		// address modes are the reserved one.
		send(ACT_BYTE, 8'd7);
		send(ACT_BYTE, 8'h01);
		send(ACT_BYTE, 8'h44);
		// A flush in the middle of a frame.
		send(ACT_BYTE, 8'd20);
		send(ACT_FLUSH, 8'hFF);
		write_pan_setting(1'b1);
		// Smallest frame: a beacon with no addresses and no payload.
		send(ACT_BYTE, 8'd7);
		send(ACT_BYTE, 8'h00);
		send(ACT_BYTE, 8'h00);
		send(ACT_BYTE, 8'h5A);
		send(ACT_BYTE, 8'hFF);
		send(ACT_BYTE, 8'h00);
		send(ACT_BYTE, 8'hA5);
		send(ACT_BYTE, 8'h3C);
		// The header fits with compression on; turning it off mid-frame brings in a
		// source PAN that no longer fits.
		send(ACT_BYTE, 8'd7);
		send(ACT_BYTE, 8'h01);
		send(ACT_BYTE, 8'h00);
		write_pan_setting(1'b0);
		send(ACT_BYTE, 8'h11);
		send(ACT_BYTE, 8'h22);
		send(ACT_BYTE, 8'h33);
		send(ACT_BYTE, 8'h44);

		for (int ph = 0; ph < 3; ph++) begin
			src_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 64 : 0;
			dst_idle_pct = (ph == 0) ? 64 : (ph == 1) ? 35 : 0;
			phase_end = bytes_sent + RANDOM_ITEMS / 3;
			while (bytes_sent < phase_end) begin
				if ($urandom_range(7) == 0)
					write_pan_setting(1'($urandom_range(1)));
				if ($urandom_range(9) == 0) begin
					repeat ($urandom_range(1, 4))
						send(1'($urandom_range(1)), 8'($urandom));
				end else begin
					send_frame();
				end
			end
		end

		wait_idle();
		$display("Sent %0d byte and flush transactions; checked %0d results, %0d whole frames",
			bytes_sent, n_results, n_frames);
		$display("and %0d length errors across three pacing regimes and %0d PAN setting writes.",
			n_len_errors, pan_writes);
		if (n_fail == 0)
			$display("PASS mac_frame_rx_parser_unit");
		else
			$display("FAIL mac_frame_rx_parser_unit");
		$finish;
	end

endmodule

### filelist.f
hdl/mfrp_pkg.sv
hdl/mfrp_front.sv
hdl/mfrp_queue.sv
hdl/mfrp_back.sv
hdl/mac_frame_rx_parser_unit.sv
tb/sv/rx_parse_checker.sv
tb/sv/testbench.sv
